[src/lrupr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_pkg
// shared constants and types for the lru page replacement block
// ----------------------------------------------------------------------------
package lrupr_pkg;

    localparam int ENTRIES_DEF = 16;   // built entry count
    localparam int KEY_W       = 32;   // page key width
    localparam int CAP_W       = 5;    // capacity register width
    localparam int CAP_RST     = 16;   // capacity after reset, before limiting
    localparam int COUNT_W     = 32;   // hit counter width
    localparam int OUT_DATA_W  = KEY_W + COUNT_W;
    localparam int OUT_USER_W  = 2;

    // control from the pipeline into the entry table
    typedef struct packed {
        logic step;    // one request is processed this cycle
        logic clear;   // request ends the sequence, clear entries afterwards
    } t_lookup_ctl;

    // per-request outcome from the entry table
    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } t_lookup_res;

endpackage

[src/lru_page_replacement.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement
// fully associative page cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// usage
//   slave stream: one request per page access, tdata = page key, tlast marks
//   the final access of a sequence
//   master stream: one response per request; tuser = {evicted, hit},
//   tdata = {hit total, evicted key}, tlast echoes the request's tlast
//   cfg port: i_cfg_wen writes the capacity (entries in use); zero acts as
//   one, values above ENTRIES act as ENTRIES; write only while idle
// timing
//   request register, one pass of tag compare and rank update, response
//   register: a request is registered, then its response; one request
//   per cycle is sustained while the master takes responses, the single
//   pass through the parallel tag compare and rank update sets that rate
// reset and stalls
//   reset empties the cache, zeroes the hit count and sets capacity to 16
//   (limited to ENTRIES); a request marked last clears entries and count
//   after its response is formed
//   a stalled master holds the response; one further request is held in the
//   request register, then tready drops until the response is taken
// ----------------------------------------------------------------------------
module lru_page_replacement #(
    parameter int ENTRIES = lrupr_pkg::ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave request stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [lrupr_pkg::KEY_W-1:0]     i_s_tdata,   // [31:0] page_key
    input  logic                            i_s_tlast,   // last
    // master response stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [lrupr_pkg::OUT_DATA_W-1:0] o_m_tdata,  // [31:0] evicted_key, [63:32] hit_total
    output logic [lrupr_pkg::OUT_USER_W-1:0] o_m_tuser,  // [0] hit, [1] evicted
    output logic                            o_m_tlast,   // done_res
    // configuration
    input  logic                            i_cfg_wen,
    input  logic [lrupr_pkg::CAP_W-1:0]     i_cfg_wdata  // capacity
);
    import lrupr_pkg::*;

    localparam int CAP_RESET = (CAP_RST > ENTRIES) ? ENTRIES : CAP_RST;

    logic [CAP_W-1:0]   r_capacity;

    // request register
    logic               r_in_valid;
    logic [KEY_W-1:0]   r_in_key;
    logic               r_in_last;

    // response register
    logic               r_out_valid;
    logic               r_out_hit;
    logic               r_out_evicted;
    logic [KEY_W-1:0]   r_out_ev_key;
    logic [COUNT_W-1:0] r_out_total;
    logic               r_out_last;

    logic [COUNT_W-1:0] r_hit_count;
    logic [COUNT_W-1:0] n_hit_count;

    logic               w_adv;     // response register can take a new result
    logic               w_step;    // request in the register is processed now
    logic               w_accept;
    t_lookup_ctl        w_ctl;
    t_lookup_res        w_res;

    assign w_adv      = !r_out_valid || i_m_tready;
    assign w_step     = r_in_valid && w_adv;
    assign o_s_tready = !r_in_valid || w_adv;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_ctl.step  = w_step;
    assign w_ctl.clear = r_in_last;

    lrupr_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_key      (r_in_key),
        .i_capacity (r_capacity),
        .o_res      (w_res)
    );

    // saturating hit count, this request included
    always_comb begin
        n_hit_count = r_hit_count;
        if (w_res.hit && (r_hit_count != '1)) begin
            n_hit_count = r_hit_count + COUNT_W'(1);
        end
    end

    // capacity register, not touched by the end of a sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_W'(CAP_RESET);
        end else if (i_cfg_wen) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_key  <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // hit counter, cleared after the last request of a sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_count <= '0;
        end else if (w_step) begin
            r_hit_count <= r_in_last ? '0 : n_hit_count;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_hit     <= w_res.hit;
            r_out_evicted <= w_res.evicted;
            r_out_ev_key  <= w_res.evicted_key;
            r_out_total   <= n_hit_count;
            r_out_last    <= r_in_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_total, r_out_ev_key};
    assign o_m_tuser  = {r_out_evicted, r_out_hit};
    assign o_m_tlast  = r_out_last;

endmodule

[src/lrupr_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_table
// fully associative key store with recency ranks, lookup and update in one pass
// ----------------------------------------------------------------------------
module lrupr_table #(
    parameter int ENTRIES = lrupr_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lrupr_pkg::t_lookup_ctl     i_ctl,
    input  logic [lrupr_pkg::KEY_W-1:0] i_key,
    input  logic [lrupr_pkg::CAP_W-1:0] i_capacity,
    output lrupr_pkg::t_lookup_res     o_res
);
    import lrupr_pkg::*;

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int USED_W = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (USED_W > CAP_W) ? USED_W : CAP_W;
    localparam int CMP_WX = (CMP_W > RANK_W) ? CMP_W : RANK_W;

    logic [KEY_W-1:0]   r_keys  [ENTRIES];
    logic [RANK_W-1:0]  r_rank  [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [USED_W-1:0]  r_used;

    logic [ENTRIES-1:0] w_match;
    logic [ENTRIES-1:0] w_free;
    logic [ENTRIES-1:0] w_lru;
    logic [ENTRIES-1:0] w_sel;
    logic [ENTRIES-1:0] w_inv;
    logic [RANK_W-1:0]  w_hit_rank;
    logic [RANK_W-1:0]  w_limit;
    logic [KEY_W-1:0]   w_ev_key;
    logic [CMP_WX-1:0]  w_cap_eff;
    logic [CMP_WX-1:0]  w_used_x;
    logic [CMP_WX-1:0]  w_worst_x;
    logic               w_hit;
    logic               w_full;
    logic               w_insert;

    // effective capacity: zero counts as one, limited to the built size
    always_comb begin
        w_cap_eff = CMP_WX'(i_capacity);
        if (i_capacity == '0) begin
            w_cap_eff = CMP_WX'(1);
        end else if (CMP_WX'(i_capacity) > CMP_WX'(ENTRIES)) begin
            w_cap_eff = CMP_WX'(ENTRIES);
        end
    end

    assign w_used_x  = CMP_WX'(r_used);
    assign w_worst_x = w_used_x - CMP_WX'(1);
    assign w_full    = (w_used_x >= w_cap_eff);

    // lowest free entry
    assign w_inv  = ~r_valid;
    assign w_free = w_inv & (~w_inv + ENTRIES'(1));

    // ranks of valid entries are always 0 .. used-1, so the oldest has rank used-1
    always_comb begin
        w_hit_rank = '0;
        w_ev_key   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_keys[i] == i_key);
            w_lru[i]   = r_valid[i] && (CMP_WX'(r_rank[i]) == w_worst_x);
            if (w_match[i]) begin
                w_hit_rank = w_hit_rank | r_rank[i];
            end
            if (w_lru[i]) begin
                w_ev_key = w_ev_key | r_keys[i];
            end
        end
    end

    assign w_hit    = |w_match;
    assign w_insert = !w_hit && !w_full;

    always_comb begin
        if (w_hit) begin
            w_sel   = w_match;
            w_limit = w_hit_rank;
        end else if (w_full) begin
            w_sel   = w_lru;
            w_limit = w_worst_x[RANK_W-1:0];
        end else begin
            w_sel   = w_free;
            w_limit = '0;
        end
    end

    assign o_res.hit         = w_hit;
    assign o_res.evicted     = !w_hit && w_full;
    assign o_res.evicted_key = (!w_hit && w_full) ? w_ev_key : '0;

    // control state: valid bits, ranks, fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_ctl.step) begin
            if (i_ctl.clear) begin
                r_valid <= '0;
                r_used  <= '0;
                for (int i = 0; i < ENTRIES; i++) begin
                    r_rank[i] <= '0;
                end
            end else begin
                if (w_insert) begin
                    r_valid <= r_valid | w_sel;
                    r_used  <= r_used + USED_W'(1);
                end
                for (int i = 0; i < ENTRIES; i++) begin
                    if (w_sel[i]) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (w_insert || r_rank[i] < w_limit)) begin
                        r_rank[i] <= r_rank[i] + RANK_W'(1);
                    end
                end
            end
        end
    end

    // key store, read only where valid
    always_ff @(posedge i_clk) begin
        if (i_ctl.step && !w_hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (w_sel[i]) begin
                    r_keys[i] <= i_key;
                end
            end
        end
    end

endmodule
